/* hw/rtl/crk4_pkg.sv */
// ----------------------------------------------------------------------------
// crk4_pkg - shared types and arithmetic for the coupled growth RK4 step
// Q8.24 words, saturating helpers and the cell plan of the pipeline.
// ----------------------------------------------------------------------------
package crk4_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned NumCells = 25;

    localparam logic [CfgIdxW-1:0] REG_STEP_SIZE       = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_GROWTH_RATE     = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_CONVERSION_RATE = 2'd2;

    localparam logic [30:0] STEP_SIZE_RESET = 31'd167772;
    // ceil(2^34 / 6), exact floor(h / 6) for any 31-bit h after >> 34
    localparam logic [31:0] RECIP_SIX = 32'hAAAA_AAAB;

    typedef struct packed {
        logic signed [31:0] a_now;
        logic signed [31:0] b_now;
        logic               last_cell;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] a_next;
        logic signed [31:0] b_next;
        logic               last_out;
    } out_word_t;

    typedef struct packed {
        logic signed [31:0] h;
        logic signed [31:0] h2;
        logic signed [31:0] h6;
        logic signed [31:0] r;
        logic signed [31:0] p;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] ta;
        logic signed [31:0] tb;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] ka;
        logic signed [31:0] kb;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic signed [63:0] pa;
        logic signed [63:0] pb;
        logic               last;
    } state_t;

    typedef enum logic [3:0] {
        OP_D1, OP_D2, OP_D3, OP_D4,
        OP_K1, OP_K2, OP_K3, OP_K4,
        OP_SM, OP_PT
    } op_t;

    localparam op_t PLAN [NumCells] = '{
        OP_D1, OP_D2, OP_D3, OP_D4, OP_K1, OP_PT,
        OP_D1, OP_D2, OP_D3, OP_D4, OP_K2, OP_PT,
        OP_D1, OP_D2, OP_D3, OP_D4, OP_K3, OP_PT,
        OP_D1, OP_D2, OP_D3, OP_D4, OP_K4, OP_SM, OP_PT
    };

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] res;
        if (v > 33'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -33'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [63:0] mul(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
        logic signed [63:0] xe;
        logic signed [63:0] ye;
        xe = 64'(x);
        ye = 64'(y);
        return xe * ye;
    endfunction

    // round to nearest (ties up), drop 24 fraction bits, saturate
    function automatic logic signed [31:0] rnd(input logic signed [63:0] prod);
        logic signed [63:0] v;
        v = prod + 64'sd8388608;
        return sat64(v >>> 24);
    endfunction

    function automatic logic signed [31:0] add_s(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
        return sat33(33'(x) + 33'(y));
    endfunction

    function automatic logic signed [31:0] sub_s(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
        return sat33(33'(x) - 33'(y));
    endfunction

    function automatic logic signed [31:0] dbl_s(input logic signed [31:0] x);
        return sat33({x, 1'b0});
    endfunction

endpackage

/* hw/rtl/crk4_cell.sv */
// ----------------------------------------------------------------------------
// crk4_cell - one stage of the RK4 cell chain
// Holds one word in flight and applies its fixed step of the integration.
// ----------------------------------------------------------------------------
module crk4_cell
    import crk4_pkg::*;
#(
    parameter op_t OP = OP_D1
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  cfg_t   cfg,
    input  logic   valid_in,
    output logic   ready_in,
    input  state_t st_in,
    output logic   valid_out,
    input  logic   ready_out,
    output state_t st_out
);

    logic   valid_reg;
    state_t st_reg;
    state_t st_next;
    logic signed [31:0] d;

    assign ready_in  = !valid_reg || ready_out;
    assign valid_out = valid_reg;
    assign st_out    = st_reg;

    always_comb begin
        st_next = st_in;
        d       = rnd(st_in.pa);
        unique case (OP)
            OP_D1: begin
                st_next.pa = mul(cfg.r, st_in.tb);
                st_next.pb = mul(cfg.p, st_in.ta);
                st_next.x  = sat33(33'sd16777216 - 33'(st_in.ta));
            end
            OP_D2: begin
                st_next.y = d;
                st_next.z = rnd(st_in.pb);
            end
            OP_D3: begin
                st_next.pa = mul(st_in.y, st_in.x);
            end
            OP_D4: begin
                st_next.ka = d;
                st_next.kb = sub_s(st_in.z, d);
            end
            OP_K1: begin
                st_next.sa = st_in.ka;
                st_next.sb = st_in.kb;
                st_next.pa = mul(cfg.h2, st_in.ka);
                st_next.pb = mul(cfg.h2, st_in.kb);
            end
            OP_K2: begin
                st_next.sa = add_s(st_in.sa, dbl_s(st_in.ka));
                st_next.sb = add_s(st_in.sb, dbl_s(st_in.kb));
                st_next.pa = mul(cfg.h2, st_in.ka);
                st_next.pb = mul(cfg.h2, st_in.kb);
            end
            OP_K3: begin
                st_next.sa = add_s(st_in.sa, dbl_s(st_in.ka));
                st_next.sb = add_s(st_in.sb, dbl_s(st_in.kb));
                st_next.pa = mul(cfg.h, st_in.ka);
                st_next.pb = mul(cfg.h, st_in.kb);
            end
            OP_K4: begin
                st_next.sa = add_s(st_in.sa, st_in.ka);
                st_next.sb = add_s(st_in.sb, st_in.kb);
            end
            OP_SM: begin
                st_next.pa = mul(cfg.h6, st_in.sa);
                st_next.pb = mul(cfg.h6, st_in.sb);
            end
            OP_PT: begin
                st_next.ta = add_s(st_in.a, d);
                st_next.tb = add_s(st_in.b, rnd(st_in.pb));
            end
            default: begin
                st_next = st_in;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_in) begin
            valid_reg <= valid_in;
        end
        if (ready_in && valid_in) begin
            st_reg <= st_next;
        end
    end

endmodule

/* hw/rtl/coupled_growth_rk4_step.sv */
// ----------------------------------------------------------------------------
// coupled_growth_rk4_step - one RK4 step of the coupled a/b growth system
// Advances one cell's Q8.24 pair (a, b) by a saturating fourth-order
// Runge-Kutta step of da = r*b*(1-a), db = p*a - da.
//
// Input words arrive on s_valid/s_ready/s_data, results leave on
// m_valid/m_ready/m_data, one result per input word, in order, with the
// last-cell flag carried alongside.
// The datapath is a chain of 25 cells, one register stage each, and a word
// passes all of them in order before its result shows on m_valid/m_data.
// One word enters per cycle while s_ready is high.
// Every cell keeps its own valid bit and takes a new word whenever it is
// empty or its neighbour takes its word, so bubbles close up and the chain
// keeps accepting while a finished result waits at the output.
// When m_ready stays low the chain fills and s_ready drops after 25 words.
// The user must write h, r and p via cfg_we/cfg_index/cfg_wdata while idle;
// the block does not enforce it. h/6 follows in the cycle after h is written.
// Reset empties the chain and sets h to about 0.01, r and p to zero.
// ----------------------------------------------------------------------------
module coupled_growth_rk4_step
    import crk4_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_word_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_word_t          m_data
);

    localparam int unsigned Depth = NumCells;

    logic [30:0]        h_reg;
    logic signed [31:0] r_reg;
    logic signed [31:0] p_reg;
    logic [28:0]        h6_reg;
    logic [62:0]        h6_prod;
    cfg_t               cfg;

    state_t st   [Depth+1];
    logic   vld  [Depth+1];
    logic   rdy  [Depth+1];

    assign h6_prod = 63'(h_reg) * 63'(RECIP_SIX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg <= STEP_SIZE_RESET;
            r_reg <= '0;
            p_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_STEP_SIZE:       h_reg <= cfg_wdata[30:0];
                REG_GROWTH_RATE:     r_reg <= cfg_wdata;
                REG_CONVERSION_RATE: p_reg <= cfg_wdata;
                default:             ;
            endcase
        end
        h6_reg <= h6_prod[62:34];
    end

    assign cfg.h  = $signed({1'b0, h_reg});
    assign cfg.h2 = $signed({2'b00, h_reg[30:1]});
    assign cfg.h6 = $signed({3'b000, h6_reg});
    assign cfg.r  = r_reg;
    assign cfg.p  = p_reg;

    always_comb begin
        st[0]      = '0;
        st[0].a    = s_data.a_now;
        st[0].b    = s_data.b_now;
        st[0].ta   = s_data.a_now;
        st[0].tb   = s_data.b_now;
        st[0].last = s_data.last_cell;
    end

    assign vld[0]  = s_valid;
    assign s_ready = rdy[0];

    for (genvar i = 0; i < Depth; i++) begin : g_cell
        crk4_cell #(
            .OP (PLAN[i])
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cfg       (cfg),
            .valid_in  (vld[i]),
            .ready_in  (rdy[i]),
            .st_in     (st[i]),
            .valid_out (vld[i+1]),
            .ready_out (rdy[i+1]),
            .st_out    (st[i+1])
        );
    end

    assign rdy[Depth]      = m_ready;
    assign m_valid         = vld[Depth];
    assign m_data.a_next   = st[Depth].ta;
    assign m_data.b_next   = st[Depth].tb;
    assign m_data.last_out = st[Depth].last;

endmodule

/* dv/tb_coupled_growth_rk4_step.sv */
// ----------------------------------------------------------------------------
// tb_coupled_growth_rk4_step - self-checking bench for the coupled RK4 step
// Drives cell words through the valid/ready input, predicts untyped results with
// a saturating Q8.24 RK4 model kept in the bench and compares each returned
// word field by field, in order. A directed table comes first (reset values,
// extremes, masked and unused register writes), then random phases with
// varied rates, sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_coupled_growth_rk4_step
    import crk4_pkg::*;
();

    typedef enum int {CFG_REAL, CFG_WIDE, CFG_EDGE} cfg_mode_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        last;
        logic        typed;
        logic [31:0] ea;
        logic [31:0] eb;
    } dir_row_t;

    localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
    localparam int DIR_ROWS = 24;
    localparam int SPLIT_A = 12;
    localparam int SPLIT_B = 20;
    localparam int NUM_PHASES = 6;
    localparam int PHASE_ITEMS = 125;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 30;

    localparam int SND_PCT [NUM_PHASES] = '{0, 78, 0, 36, 0, 36};
    localparam int RCV_PCT [NUM_PHASES] = '{0, 0, 78, 36, 0, 36};
    localparam cfg_mode_t PHASE_CFG [NUM_PHASES] =
        '{CFG_REAL, CFG_WIDE, CFG_REAL, CFG_EDGE, CFG_REAL, CFG_WIDE};

    // with r = p = 0 or h = 0 the step leaves a and b untouched
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
        '{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF},
        '{32'h0100_0000, 32'h0100_0000, 1'b1, 1'b1, 32'h0100_0000, 32'h0100_0000},
        '{32'hFF00_0000, 32'h0200_0000, 1'b0, 1'b1, 32'hFF00_0000, 32'h0200_0000},
        '{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0001, 32'hFFFF_FFFF},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA},
        '{32'h0080_0000, 32'h0040_0000, 1'b0, 1'b1, 32'h0080_0000, 32'h0040_0000},
        '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_0001},
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 32'h0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0, 32'h0},
        '{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 32'h0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 32'h0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0},
        '{32'h0100_0000, 32'h0100_0000, 1'b0, 1'b0, 32'h0, 32'h0},
        '{32'h0080_0000, 32'h0080_0000, 1'b1, 1'b0, 32'h0, 32'h0},
        '{32'hFF00_0000, 32'hFF00_0000, 1'b0, 1'b0, 32'h0, 32'h0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000},
        '{32'h0100_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h0100_0000, 32'h0000_0000},
        '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF}
    };

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [31:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_word_t           s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_word_t          m_data;

    longint    step_h = 167772;
    longint    rate_r = 0;
    longint    rate_p = 0;
    out_word_t next_pop_q [$];
    int        errors = 0;
    int        snd_idle_pct = 0;
    int        rcv_stall_pct = 0;
    bit        hold_req = 1'b0;
    int        hold_left = 0;

    coupled_growth_rk4_step DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint clip32(input longint v);
        longint res;
        if (v > 64'sd2147483647) begin
            res = 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            res = -64'sd2147483648;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic longint q_mul(input longint x, input longint y);
        longint prod;
        prod = x * y + 64'sd8388608;
        return clip32(prod >>> 24);
    endfunction

    function automatic void growth_slope(input longint ta, input longint tb,
                                         output longint da, output longint db);
        longint om;
        om = clip32(64'sd16777216 - ta);
        da = q_mul(q_mul(rate_r, tb), om);
        db = clip32(q_mul(rate_p, ta) - da);
    endfunction

    function automatic out_word_t rk4_advance(input in_word_t w);
        longint    a;
        longint    b;
        longint    h2;
        longint    h6;
        longint    hs;
        longint    sa;
        longint    sb;
        longint    ka [4];
        longint    kb [4];
        out_word_t res;
        a = longint'(w.a_now);
        b = longint'(w.b_now);
        h2 = step_h >>> 1;
        h6 = step_h / 6;
        growth_slope(a, b, ka[0], kb[0]);
        for (int i = 1; i < 4; i++) begin
            hs = (i == 3) ? step_h : h2;
            growth_slope(clip32(a + q_mul(hs, ka[i-1])), clip32(b + q_mul(hs, kb[i-1])),
                         ka[i], kb[i]);
        end
        sa = clip32(ka[0] + clip32(2 * ka[1]));
        sa = clip32(sa + clip32(2 * ka[2]));
        sa = clip32(sa + ka[3]);
        sb = clip32(kb[0] + clip32(2 * kb[1]));
        sb = clip32(sb + clip32(2 * kb[2]));
        sb = clip32(sb + kb[3]);
        res.a_next = 32'(clip32(a + q_mul(h6, sa)));
        res.b_next = 32'(clip32(b + q_mul(h6, sb)));
        res.last_out = w.last_cell;
        return res;
    endfunction

    function automatic logic [31:0] pick_extreme();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h0000_0000;
            default: v = 32'h0100_0000;
        endcase
        return v;
    endfunction

    function automatic in_word_t random_cell();
        int       k;
        in_word_t w;
        k = $urandom_range(0, 9);
        if (k < 6) begin
            w.a_now = 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
            w.b_now = 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
        end else if (k < 9) begin
            w.a_now = $urandom;
            w.b_now = $urandom;
        end else begin
            w.a_now = pick_extreme();
            w.b_now = pick_extreme();
        end
        w.last_cell = ($urandom_range(0, 7) == 0);
        return w;
    endfunction

    // called and left at a falling edge
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_STEP_SIZE:       step_h = longint'(val[30:0]);
            REG_GROWTH_RATE:     rate_r = longint'($signed(val));
            REG_CONVERSION_RATE: rate_p = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic apply_config(input cfg_mode_t mode);
        logic [31:0] h;
        logic [31:0] r;
        logic [31:0] p;
        case (mode)
            CFG_REAL: begin
                h = $urandom_range(0, 32'h0100_0000);
                r = 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
                p = 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
            end
            CFG_WIDE: begin
                h = $urandom;
                r = $urandom;
                p = $urandom;
            end
            default: begin
                h = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0000_0000;
                r = pick_extreme();
                p = pick_extreme();
            end
        endcase
        write_reg(REG_STEP_SIZE, h);
        write_reg(REG_GROWTH_RATE, r);
        write_reg(REG_CONVERSION_RATE, p);
        repeat (4) @(negedge aclk);
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (next_pop_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic offer_cell(input in_word_t w, input bit typed, input out_word_t want);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = w;
        do @(posedge aclk); while (!s_ready);
        next_pop_q.push_back(typed ? want : rk4_advance(w));
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (next_pop_q.size() == 0) begin
                errors++;
                $display("%0t: word with nothing expected: a=%h b=%h last=%b",
                         $time, m_data.a_next, m_data.b_next, m_data.last_out);
            end else begin
                want = next_pop_q.pop_front();
                if (m_data.a_next !== want.a_next) begin
                    errors++;
                    $display("%0t: a_next expected %h got %h",
                             $time, want.a_next, m_data.a_next);
                end
                if (m_data.b_next !== want.b_next) begin
                    errors++;
                    $display("%0t: b_next expected %h got %h",
                             $time, want.b_next, m_data.b_next);
                end
                if (m_data.last_out !== want.last_out) begin
                    errors++;
                    $display("%0t: last_out expected %b got %b",
                             $time, want.last_out, m_data.last_out);
                end
            end
        end
    end

    initial begin
        in_word_t  w;
        out_word_t want;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (i == SPLIT_A) begin
                settle();
                write_reg(REG_STEP_SIZE, 32'h7FFF_FFFF);
                write_reg(REG_GROWTH_RATE, 32'h7FFF_FFFF);
                write_reg(REG_CONVERSION_RATE, 32'h8000_0000);
                repeat (4) @(negedge aclk);
            end
            if (i == SPLIT_B) begin
                // bit 31 of the step is dropped, so h = 0; index 3 hits nothing
                settle();
                write_reg(REG_STEP_SIZE, 32'h8000_0000);
                write_reg(REG_GROWTH_RATE, 32'h8000_0000);
                write_reg(REG_CONVERSION_RATE, 32'h7FFF_FFFF);
                write_reg(REG_UNUSED, 32'h0100_0000);
                repeat (4) @(negedge aclk);
            end
            w.a_now = DIR_TAB[i].a;
            w.b_now = DIR_TAB[i].b;
            w.last_cell = DIR_TAB[i].last;
            want.a_next = DIR_TAB[i].ea;
            want.b_next = DIR_TAB[i].eb;
            want.last_out = DIR_TAB[i].last;
            offer_cell(w, DIR_TAB[i].typed, want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            snd_idle_pct = SND_PCT[ph];
            rcv_stall_pct = RCV_PCT[ph];
            apply_config(PHASE_CFG[ph]);
            if (ph == PRESSURE_PHASE)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_cell(random_cell(), 1'b0, '0);
        end

        settle();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/crk4_pkg.sv
hw/rtl/crk4_cell.sv
hw/rtl/coupled_growth_rk4_step.sv
dv/tb_coupled_growth_rk4_step.sv
